FILE: sv/i2c_master_transaction_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// I2C master transaction sequencer: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CMTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/i2cmts_pkg.sv
// ----------------------------------------------------------------------------
// I2C master transaction sequencer package
// Operation and status codes, register indexes and the command structures
// passed between the decoder and the top level.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

	// Default depth of the transfer buffer.
	localparam int BUFFER_DEPTH_DEF = 16;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_LENGTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_READ_LENGTH   = 2'd2;

	// Operations carried by an input beat.
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_STATUS = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// Bus engine status codes.
	localparam logic [7:0] ST_START        = 8'h08;
	localparam logic [7:0] ST_REP_START    = 8'h10;
	localparam logic [7:0] ST_ADDR_W_ACK   = 8'h18;
	localparam logic [7:0] ST_ADDR_W_NACK  = 8'h20;
	localparam logic [7:0] ST_DATA_W_ACK   = 8'h28;
	localparam logic [7:0] ST_DATA_W_NACK  = 8'h30;
	localparam logic [7:0] ST_ADDR_R_ACK   = 8'h40;
	localparam logic [7:0] ST_ADDR_R_NACK  = 8'h48;
	localparam logic [7:0] ST_DATA_R_ACK   = 8'h50;
	localparam logic [7:0] ST_DATA_R_NACK  = 8'h58;

	// Acknowledge actions.
	localparam logic [1:0] ACK_NONE     = 2'd0;
	localparam logic [1:0] ACK_ENABLE   = 2'd1;
	localparam logic [1:0] ACK_DISABLE  = 2'd2;
	localparam logic [1:0] ACK_RESERVED = 2'd3;

	// Engine command for one beat, as decoded.
	typedef struct packed {
		logic       send_valid;
		logic       send_from_buf;
		logic [7:0] send_imm;
		logic       set_msb;
		logic       request_start;
		logic       clear_start;
		logic       request_stop;
		logic [1:0] ack_action;
		logic       read_buf;
	} cmd_t;

	// State and buffer updates for one beat.
	typedef struct packed {
		logic start;
		logic ptr_adv;
		logic wl_dec;
		logic rl_dec;
		logic set_done;
		logic mem_we;
		logic mem_re;
		logic mem_at_ptr;
	} upd_t;

endpackage

FILE: sv/i2cmts_cmd_if.sv
// ----------------------------------------------------------------------------
// I2C master transaction sequencer: input channel
// Valid/ready channel carrying one operation beat to the sequencer.
// ----------------------------------------------------------------------------
interface i2cmts_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [3:0] buffer_index;
	logic [7:0] byte_value;
	logic [7:0] bus_status;

	modport source (
		output valid, operation, buffer_index, byte_value, bus_status,
		input  ready
	);

	modport sink (
		input  valid, operation, buffer_index, byte_value, bus_status,
		output ready
	);
endinterface

FILE: sv/i2cmts_rsp_if.sv
// ----------------------------------------------------------------------------
// I2C master transaction sequencer: result channel
// Valid/ready channel carrying one engine command beat from the sequencer.
// ----------------------------------------------------------------------------
interface i2cmts_rsp_if;
	logic       valid;
	logic       ready;
	logic       send_valid;
	logic [7:0] send_byte;
	logic       request_start;
	logic       clear_start;
	logic       request_stop;
	logic [1:0] ack_action;
	logic       xfer_done;
	logic [7:0] buffer_byte;

	modport source (
		output valid, send_valid, send_byte, request_start, clear_start,
		       request_stop, ack_action, xfer_done, buffer_byte,
		input  ready
	);

	modport sink (
		input  valid, send_valid, send_byte, request_start, clear_start,
		       request_stop, ack_action, xfer_done, buffer_byte,
		output ready
	);
endinterface

FILE: sv/i2cmts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module i2cmts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read; the read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: sv/i2cmts_dec.sv
// ----------------------------------------------------------------------------
// I2C master transaction sequencer: beat decoder
// Turns one operation or bus status event into an engine command and the
// matching counter, pointer and buffer updates.
// ----------------------------------------------------------------------------
module i2cmts_dec (
	input  logic [1:0]        operation,
	input  logic [7:0]        bus_status,
	input  logic [6:0]        slave_address,
	input  logic [4:0]        writes_left,
	input  logic [4:0]        reads_left,
	output i2cmts_pkg::cmd_t  command,
	output i2cmts_pkg::upd_t  update
);
	import i2cmts_pkg::*;

	// Main decode of operation and status code.
	always_comb begin
		command = '0;
		update  = '0;
		unique case (operation)
			OP_LOAD: begin
				update.mem_we = 1'b1;
			end
			OP_START: begin
				update.start          = 1'b1;
				command.request_start = 1'b1;
			end
			OP_STATUS: begin
				unique case (bus_status) inside
					ST_START, ST_REP_START: begin
						// Address byte: read direction once no writes remain.
						command.send_valid  = 1'b1;
						command.send_imm    = {slave_address, (writes_left == 5'd0)};
						command.clear_start = 1'b1;
					end
					ST_ADDR_W_ACK, ST_DATA_W_ACK: begin
						if (writes_left != 5'd0) begin
							// Next write byte; the first one flags auto-increment when more than one read remains.
							command.send_valid    = 1'b1;
							command.send_from_buf = 1'b1;
							command.set_msb       = (bus_status == ST_ADDR_W_ACK) &&
							                        (reads_left > 5'd1);
							update.mem_re         = 1'b1;
							update.mem_at_ptr     = 1'b1;
							update.ptr_adv        = 1'b1;
							update.wl_dec         = 1'b1;
						end else if (reads_left == 5'd0) begin
							command.request_stop = 1'b1;
							update.set_done      = 1'b1;
						end else begin
							command.request_start = 1'b1;
						end
					end
					ST_ADDR_W_NACK, ST_DATA_W_NACK, ST_ADDR_R_NACK: begin
						command.request_stop = 1'b1;
						update.set_done      = 1'b1;
					end
					ST_ADDR_R_ACK: begin
						command.ack_action = (reads_left <= 5'd1) ? ACK_DISABLE : ACK_ENABLE;
					end
					ST_DATA_R_ACK: begin
						if (reads_left == 5'd0) begin
							command.ack_action = ACK_DISABLE;
						end else begin
							// Store the byte; withdraw ACK when one byte remains.
							update.mem_we     = 1'b1;
							update.mem_at_ptr = 1'b1;
							update.ptr_adv    = 1'b1;
							update.rl_dec     = 1'b1;
							if (reads_left <= 5'd2) begin
								command.ack_action = ACK_DISABLE;
							end
						end
					end
					ST_DATA_R_NACK: begin
						// The final NACKed byte is still kept while reads remain.
						if (reads_left != 5'd0) begin
							update.mem_we     = 1'b1;
							update.mem_at_ptr = 1'b1;
							update.ptr_adv    = 1'b1;
							update.rl_dec     = 1'b1;
						end
						command.request_stop = 1'b1;
						update.set_done      = 1'b1;
					end
					default: begin
					end
				endcase
			end
			OP_READ: begin
				update.mem_re    = 1'b1;
				command.read_buf = 1'b1;
			end
			default: begin
			end
		endcase
	end
endmodule

FILE: sv/i2c_master_transaction_sequencer_core.sv
// ----------------------------------------------------------------------------
// I2C master transaction sequencer core
// Drives a byte-level I2C engine through one write-then-read transaction.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one operation per beat: load a buffer byte, start the
//   transaction, report an engine status event (with any received byte), or
//   read a buffer byte back. rsp returns exactly one command beat for each
//   cmd beat, in order: the byte to send, start, clear start, stop, the ACK
//   action, the done flag and, for a buffer read, the buffer byte.
//   Slave address and the two lengths are to be written through the cfg port
//   only while no beat is in flight; the block does not enforce this.
//   A beat accepted on cmd is offered on rsp from the next cycle. Throughput
//   is one beat per cycle while rsp is not stalled; the transfer buffer is
//   a RAM with a registered read port, and that read register sets the
//   single stage.
//   Reset empties the result stage, clears pointer and counters, sets the
//   done flag and clears the configuration. Buffer contents stay undefined
//   until loaded. While rsp is stalled the result holds, and cmd keeps
//   accepting only as long as the result stage is free.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_core #(
	parameter int BUFFER_DEPTH = i2cmts_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [i2cmts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [i2cmts_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	i2cmts_cmd_if.sink                           cmd,
	i2cmts_rsp_if.source                         rsp
);
	import i2cmts_pkg::*;

	localparam int PTR_W = $clog2(BUFFER_DEPTH);

	logic [6:0]       slave_address_q;
	logic [4:0]       write_length_q;
	logic [4:0]       read_length_q;
	logic [PTR_W-1:0] ptr_q;
	logic [4:0]       writes_left_q;
	logic [4:0]       reads_left_q;
	logic             done_q;
	logic             done_next;
	logic             accept;
	logic [4:0]       idx_red;
	logic [PTR_W-1:0] idx_mod;
	logic [PTR_W-1:0] mem_addr;
	logic [7:0]       mem_rdata;
	cmd_t             command;
	upd_t             update;
	logic             valid_s1;
	cmd_t             cmd_s1;
	logic             done_s1;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= '0;
			write_length_q  <= '0;
			read_length_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SLAVE_ADDRESS: slave_address_q <= cfg_wdata;
				REG_WRITE_LENGTH:  write_length_q  <= cfg_wdata[4:0];
				REG_READ_LENGTH:   read_length_q   <= cfg_wdata[4:0];
				default: begin
				end
			endcase
		end
	end

	// Decode of the incoming beat against the current state.
	i2cmts_dec u_dec (
		.operation     (cmd.operation),
		.bus_status    (cmd.bus_status),
		.slave_address (slave_address_q),
		.writes_left   (writes_left_q),
		.reads_left    (reads_left_q),
		.command       (command),
		.update        (update)
	);

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = !valid_s1 || rsp.ready;

	// Buffer index reduced modulo the buffer depth by repeated subtraction.
	always_comb begin
		idx_red = {1'b0, cmd.buffer_index};
		for (int i = 0; i < 8; i++) begin
			if (int'(idx_red) >= BUFFER_DEPTH) begin
				idx_red = idx_red - 5'(BUFFER_DEPTH);
			end
		end
		idx_mod = PTR_W'(idx_red);
	end

	assign mem_addr  = update.mem_at_ptr ? ptr_q : idx_mod;
	assign done_next = update.start ? 1'b0 : (update.set_done ? 1'b1 : done_q);

	// Transfer buffer.
	i2cmts_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (accept && update.mem_we),
		.waddr (mem_addr),
		.wdata (cmd.byte_value),
		.re    (accept && update.mem_re),
		.raddr (mem_addr),
		.rdata (mem_rdata)
	);

	// Pointer, byte counters and done flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q         <= '0;
			writes_left_q <= '0;
			reads_left_q  <= '0;
			done_q        <= 1'b1;
		end else if (accept) begin
			done_q <= done_next;
			if (update.start) begin
				ptr_q         <= '0;
				writes_left_q <= write_length_q;
				reads_left_q  <= read_length_q;
			end else begin
				if (update.ptr_adv) begin
					ptr_q <= (ptr_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
				end
				if (update.wl_dec) begin
					writes_left_q <= writes_left_q - 5'd1;
				end
				if (update.rl_dec) begin
					reads_left_q <= reads_left_q - 5'd1;
				end
			end
		end
	end

	// Result stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Result stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			done_s1 <= done_next;
		end
	end

	// Result beat, with the buffer byte merged in from the RAM read register.
	assign rsp.valid            = valid_s1;
	assign rsp.send_valid       = cmd_s1.send_valid;
	assign rsp.send_byte        = !cmd_s1.send_valid ? 8'h00 :
	                              cmd_s1.send_from_buf ? (mem_rdata | {cmd_s1.set_msb, 7'b0}) :
	                              cmd_s1.send_imm;
	assign rsp.request_start    = cmd_s1.request_start;
	assign rsp.clear_start      = cmd_s1.clear_start;
	assign rsp.request_stop     = cmd_s1.request_stop;
	assign rsp.ack_action       = cmd_s1.ack_action;
	assign rsp.xfer_done        = done_s1;
	assign rsp.buffer_byte      = cmd_s1.read_buf ? mem_rdata : 8'h00;
endmodule

FILE: sv/i2cmts_checker.sv
// ----------------------------------------------------------------------------
// I2C master transaction sequencer: port checker
// Concurrent checks on the top level's channels, attached by bind.
// ----------------------------------------------------------------------------
`include "i2c_master_transaction_sequencer_core_defines.svh"

module i2cmts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic [1:0] cmd_operation,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_send_valid,
	input logic [7:0] rsp_send_byte,
	input logic       rsp_request_start,
	input logic       rsp_request_stop,
	input logic [1:0] rsp_ack_action,
	input logic       rsp_xfer_done
);
	import i2cmts_pkg::*;

	// A stalled result beat stays offered, with its send byte unchanged.
	`I2CMTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_send_byte), "stalled result beat changed")

	// A start is answered in the next cycle with a start request and done low.
	`I2CMTS_ASSERT_NEXT(a_start_rsp, cmd_valid && cmd_ready && (cmd_operation == OP_START), rsp_valid && rsp_request_start && !rsp_xfer_done, "start not answered")

	// A stop always ends the transaction.
	`I2CMTS_ASSERT_NOW(a_stop_done, rsp_valid && rsp_request_stop, rsp_xfer_done, "stop without done")

	// No reserved ACK action, and no stray send byte.
	`I2CMTS_ASSERT_NOW(a_cmd_clean, rsp_valid, (rsp_ack_action != ACK_RESERVED) && (rsp_send_valid || (rsp_send_byte == 8'h00)), "malformed command beat")
endmodule

bind i2c_master_transaction_sequencer_core i2cmts_checker u_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.cmd_valid            (cmd.valid),
	.cmd_ready            (cmd.ready),
	.cmd_operation        (cmd.operation),
	.rsp_valid            (rsp.valid),
	.rsp_ready            (rsp.ready),
	.rsp_send_valid       (rsp.send_valid),
	.rsp_send_byte        (rsp.send_byte),
	.rsp_request_start    (rsp.request_start),
	.rsp_request_stop     (rsp.request_stop),
	.rsp_ack_action       (rsp.ack_action),
	.rsp_xfer_done        (rsp.xfer_done)
);
